### hw/rtl/dpq_pkg.sv
package dpq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 9;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 80;

  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_MAX = 2'd1,
    CMD_REMOVE_MIN = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch incoming request
    logic exec;     // apply removal / overflow, start insert walk
    logic shift;    // move compared entry one slot up, pos--
    logic put;      // write new value at pos, count++
    logic sel_min;  // read address: bottom of queue
    logic sel_walk; // read address: entry below pos
    logic cap_min;  // capture min from read data
    logic out_load; // load result register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_ok;   // insert with room
    logic pos_zero;
    logic greater;  // read entry > new value
    logic out_busy;
    logic full;
  } sts_t;

  // circular address: base + off, wrapped into the store
  function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W+ADDR_W-1:0] sum;
    logic [CNT_W+ADDR_W-1:0] cap;
    sum = (CNT_W+ADDR_W)'(base) + (CNT_W+ADDR_W)'(off);
    cap = (CNT_W+ADDR_W)'(CAPACITY);
    if (sum >= cap) sum = sum - cap;
    if (sum >= cap) sum = sum - cap;
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### hw/rtl/double_ended_priority_queue_top.sv
// Double-ended priority queue of signed 32-bit values.
// Input stream (s_*): one request per beat, tdata = {value, cmd}; cmd 0 inserts
//   value, 1 removes the maximum, 2 removes the minimum, 3 does nothing.
// Output stream (m_*): exactly one result per request, in order, holding the
//   max and min after the request (zero when empty), an empty flag, the
//   occupancy and an overflow flag set when an insert hit a full queue.
// Values live in a 256-entry store with one read and one write port, kept
//   sorted as a circular window: remove-min advances the base, remove-max
//   shrinks the count. Removals, no-ops and dropped inserts pass EXEC,
//   RD_MIN, RD_MAX and DONE, where the result register is loaded; the next
//   request is taken back in IDLE. An insert walks down from the top, with a
//   registered read (SH_CHK), then compare and move (SH_CMP) per entry, over
//   the stored values larger than the new one, then goes on to RD_MIN.
// One request is in work at a time; s_tready is high only between requests.
// The result register lets the next request be accepted while the previous
//   result still waits; if the receiver stalls, the finished request holds
//   in the controller until the result register frees up.
// Reset (synchronous, rst high) empties the queue and drops any pending
//   result; store contents need no clearing.
module double_ended_priority_queue_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [dpq_pkg::IN_W-1:0]  s_tdata,   // cmd[1:0], value[33:2], zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [dpq_pkg::OUT_W-1:0] m_tdata    // max_value[31:0], min_value[63:32],
                                               // is_empty[64], occupancy[73:65],
                                               // overflow[74], zero pad
);
  import dpq_pkg::*;

  ctl_t             ctl;
  sts_t             sts;
  logic [VAL_W-1:0] max_value;
  logic [VAL_W-1:0] min_value;
  logic             is_empty;
  logic [OCC_W-1:0] occupancy;
  logic             overflow;

  dpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  dpq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (s_tdata[1:0]),
    .value     (s_tdata[33:2]),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .max_value (max_value),
    .min_value (min_value),
    .is_empty  (is_empty),
    .occupancy (occupancy),
    .overflow  (overflow)
  );

  assign m_tdata = {5'd0, overflow, occupancy, is_empty, min_value, max_value};

  // empty result reports zero for both ends
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && is_empty |-> (max_value == '0) && (min_value == '0))
    else $error("empty result with nonzero max/min");

  // a dropped insert only happens on a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && overflow |-> (occupancy == OCC_W'(CAPACITY)))
    else $error("overflow without full queue");

  // nonempty result keeps max at or above min
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !is_empty |-> $signed(max_value) >= $signed(min_value))
    else $error("max below min");

endmodule

### hw/rtl/dpq_ctrl.sv
module dpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpq_pkg::sts_t sts,
  output dpq_pkg::ctl_t ctl
);
  import dpq_pkg::*;

  typedef enum logic [2:0] {
    IDLE, EXEC, SH_CHK, SH_CMP, RD_MIN, RD_MAX, DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = EXEC;
        end
      end
      EXEC: begin
        ctl.exec = 1'b1;
        state_next = sts.ins_ok ? SH_CHK : RD_MIN;
      end
      SH_CHK: begin
        ctl.sel_walk = 1'b1;
        if (sts.pos_zero) begin
          ctl.put = 1'b1;
          state_next = RD_MIN;
        end else begin
          state_next = SH_CMP;
        end
      end
      SH_CMP: begin
        if (sts.greater) begin
          ctl.shift = 1'b1;
          state_next = SH_CHK;
        end else begin
          ctl.put = 1'b1;
          state_next = RD_MIN;
        end
      end
      RD_MIN: begin
        ctl.sel_min = 1'b1;
        state_next = RD_MAX;
      end
      RD_MAX: begin
        ctl.cap_min = 1'b1;
        state_next = DONE;
      end
      DONE: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end

endmodule

### hw/rtl/dpq_dp.sv
module dpq_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                cmd,
  input  logic [dpq_pkg::VAL_W-1:0] value,
  input  dpq_pkg::ctl_t             ctl,
  output dpq_pkg::sts_t             sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dpq_pkg::VAL_W-1:0] max_value,
  output logic [dpq_pkg::VAL_W-1:0] min_value,
  output logic                      is_empty,
  output logic [dpq_pkg::OCC_W-1:0] occupancy,
  output logic                      overflow
);
  import dpq_pkg::*;

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  logic [1:0]        cmd_r;
  logic [VAL_W-1:0]  val_r;
  logic              ovf_r;
  logic [VAL_W-1:0]  min_r;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign sts.full     = (count == CNT_W'(CAPACITY));
  assign sts.ins_ok   = (cmd_r == CMD_INSERT) && !sts.full;
  assign sts.pos_zero = (pos == '0);
  assign sts.greater  = $signed(rdata) > $signed(val_r);
  assign sts.out_busy = out_valid && !out_ready;

  always_comb begin
    if (ctl.sel_min) rd_addr = base;
    else if (ctl.sel_walk) rd_addr = addr_add(base, pos - CNT_W'(1));
    else rd_addr = addr_add(base, count - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (ctl.shift) mem[addr_add(base, pos)] <= rdata;
    if (ctl.put) mem[addr_add(base, pos)] <= val_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd;
      val_r <= value;
    end
    if (ctl.exec) pos <= count;
    else if (ctl.shift) pos <= pos - CNT_W'(1);
    if (ctl.cap_min) min_r <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      count <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (ctl.load) ovf_r <= 1'b0;
      if (ctl.exec) begin
        priority case (cmd_r)
          CMD_INSERT: ovf_r <= sts.full;
          CMD_REMOVE_MAX: if (count != '0) count <= count - CNT_W'(1);
          CMD_REMOVE_MIN: begin
            if (count != '0) begin
              count <= count - CNT_W'(1);
              base  <= addr_add(base, CNT_W'(1));
            end
          end
          default: ;
        endcase
      end
      if (ctl.put) count <= count + CNT_W'(1);
    end
  end

  assign occ_ext = (CNT_W+OCC_W)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      is_empty  <= (count == '0);
      max_value <= (count == '0) ? '0 : rdata;
      min_value <= (count == '0) ? '0 : min_r;
      occupancy <= occ_ext[OCC_W-1:0];
      overflow  <= ovf_r;
    end
  end

endmodule
